/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LLBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is held.
`define LLBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/llbd_pkg.sv */
`timescale 1ns / 1ps

package llbd_pkg;

  // Fraction bits of the y field; the squared x term is scaled to match.
  localparam int Y_FRAC    = 8;
  localparam int SQ_SHIFT  = 2 * Y_FRAC;

  // Squared distance width, saturating.
  localparam int DIST_BITS = 51;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  // Largest x square that still fits after scaling.
  localparam logic [DIST_BITS-1:0] XS_LIMIT = DIST_MAX >> SQ_SHIFT;

  // Bucket size register and fill counter width.
  localparam int CNT_BITS  = 16;

  // Output queue depth and its count width.
  localparam int Q_DEPTH   = 2;
  localparam int Q_CNT_W   = 2;

  // Number of results one input item causes.
  localparam logic [1:0] NRES_NONE = 2'd0;
  localparam logic [1:0] NRES_ONE  = 2'd1;
  localparam logic [1:0] NRES_TWO  = 2'd2;

endpackage

/* rtl/longest_line_bucket_downsampler.sv */
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)       tuser          tlast
// in_       slave      point_x, point_y         series_first   series_last
// out_      master     out_x, out_y             is_endpoint    last_of_run
// cfg_      slave      cfg_data = bucket_size   -              -
//
// One item per cycle sustained while the result queue has room. An item sits
// in the input register, where the distance compare and state update run,
// then its results land in a two-entry result queue that drives the output.
// The distance path (two squares, add, compare against the kept distance) is
// the one register-to-register path that sets the clock.
// Reset (rst_n low, synchronous) clears anchor, kept point, fill count and
// queue, and sets bucket_size to one. A stalled output holds its beat; input
// keeps flowing until the queue cannot take the next item's results.
module longest_line_bucket_downsampler #(
  parameter int X_BITS = 16,
  parameter int Y_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // point_x, point_y, zero pad
  input  logic [((X_BITS+Y_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // series_first
  input  logic                                   in_tuser,
  input  logic                                   in_tlast,
  // out_x, out_y, zero pad
  output logic [((X_BITS+Y_BITS+7)/8)*8-1:0]     out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // is_endpoint
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [llbd_pkg::CNT_BITS-1:0]          cfg_data
);

  localparam int TD_W  = ((X_BITS + Y_BITS + 7) / 8) * 8;
  // Queue entry: {last_of_run, is_endpoint, y, x}
  localparam int RES_W = X_BITS + Y_BITS + 2;

  // Input register
  logic                             in_valid_r;
  logic [X_BITS-1:0]                px_r;
  logic [Y_BITS-1:0]                py_r;
  logic                             first_r;
  logic                             last_r;

  // Running state
  logic [llbd_pkg::CNT_BITS-1:0]    bsize_r;
  logic [X_BITS-1:0]                anchor_x_r, anchor_x_nxt;
  logic [Y_BITS-1:0]                anchor_y_r, anchor_y_nxt;
  logic [X_BITS-1:0]                best_x_r, best_x_nxt;
  logic [Y_BITS-1:0]                best_y_r, best_y_nxt;
  logic [llbd_pkg::DIST_BITS-1:0]   best_d_r, best_d_nxt;
  logic [llbd_pkg::CNT_BITS-1:0]    fill_r, fill_nxt;

  logic [llbd_pkg::DIST_BITS-1:0]   dist_sq;
  logic [llbd_pkg::CNT_BITS-1:0]    limit;
  logic [llbd_pkg::CNT_BITS-1:0]    fill_inc;
  logic                             take;
  logic [X_BITS-1:0]                keep_x;
  logic [Y_BITS-1:0]                keep_y;

  logic [1:0]                       nres;
  logic [RES_W-1:0]                 res0;
  logic [RES_W-1:0]                 res1;
  logic                             fire;
  logic                             pop;
  logic [llbd_pkg::Q_CNT_W:0]       room_chk;
  logic [llbd_pkg::Q_CNT_W-1:0]     q_count;
  logic                             q_valid;
  logic [RES_W-1:0]                 q_head;

  // The user must write configuration only while idle; the block does not enforce this and always takes it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= llbd_pkg::CNT_BITS'(1);
    end else if (cfg_valid) begin
      bsize_r <= cfg_data;
    end
  end

  // Advance the input register when empty or when its item fires.
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      px_r    <= in_tdata[X_BITS-1:0];
      py_r    <= in_tdata[X_BITS+Y_BITS-1:X_BITS];
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  llbd_dist #(
    .X_BITS (X_BITS),
    .Y_BITS (Y_BITS)
  ) u_dist (
    .px      (px_r),
    .py      (py_r),
    .ax      (anchor_x_r),
    .ay      (anchor_y_r),
    .dist_sq (dist_sq)
  );

  // A bucket size of zero acts as one.
  assign limit    = (bsize_r == '0) ? llbd_pkg::CNT_BITS'(1) : bsize_r;
  assign fill_inc = fill_r + llbd_pkg::CNT_BITS'(1);
  assign take     = (dist_sq > best_d_r);
  assign keep_x   = take ? px_r : best_x_r;
  assign keep_y   = take ? py_r : best_y_r;

  // Result count and state update for the item in the input register.
  always_comb begin
    nres         = llbd_pkg::NRES_NONE;
    res0         = {1'b1, 1'b1, py_r, px_r};
    res1         = {1'b1, 1'b1, py_r, px_r};
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    best_x_nxt   = best_x_r;
    best_y_nxt   = best_y_r;
    best_d_nxt   = best_d_r;
    fill_nxt     = fill_r;
    if (first_r || last_r) begin
      // Endpoint: flush an open bucket on the last point, restart here.
      if (!first_r && (fill_r != '0)) begin
        nres = llbd_pkg::NRES_TWO;
        res0 = {1'b0, 1'b0, best_y_r, best_x_r};
      end else begin
        nres = llbd_pkg::NRES_ONE;
      end
      anchor_x_nxt = px_r;
      anchor_y_nxt = py_r;
      best_x_nxt   = px_r;
      best_y_nxt   = py_r;
      best_d_nxt   = '0;
      fill_nxt     = '0;
    end else if (fill_inc >= limit) begin
      // Bucket full: emit the kept point and make it the new anchor.
      nres         = llbd_pkg::NRES_ONE;
      res0         = {1'b1, 1'b0, keep_y, keep_x};
      anchor_x_nxt = keep_x;
      anchor_y_nxt = keep_y;
      best_x_nxt   = keep_x;
      best_y_nxt   = keep_y;
      best_d_nxt   = '0;
      fill_nxt     = '0;
    end else begin
      if (take) begin
        best_x_nxt = px_r;
        best_y_nxt = py_r;
        best_d_nxt = dist_sq;
      end
      fill_nxt = fill_inc;
    end
  end

  // Fire when the queue, after this cycle's pop, has room for all results.
  assign pop      = q_valid && out_tready;
  assign room_chk = {1'b0, q_count} - (llbd_pkg::Q_CNT_W + 1)'(pop)
                    + {1'b0, nres};
  assign fire     = in_valid_r && (room_chk <= (llbd_pkg::Q_CNT_W + 1)'(llbd_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_x_r <= '0;
      anchor_y_r <= '0;
      best_x_r   <= '0;
      best_y_r   <= '0;
      best_d_r   <= '0;
      fill_r     <= '0;
    end else if (fire) begin
      anchor_x_r <= anchor_x_nxt;
      anchor_y_r <= anchor_y_nxt;
      best_x_r   <= best_x_nxt;
      best_y_r   <= best_y_nxt;
      best_d_r   <= best_d_nxt;
      fill_r     <= fill_nxt;
    end
  end

  llbd_outq #(
    .W (RES_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (fire ? nres : llbd_pkg::NRES_NONE),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  assign out_tvalid = q_valid;
  assign out_tdata  = TD_W'(q_head[X_BITS+Y_BITS-1:0]);
  assign out_tuser  = q_head[X_BITS+Y_BITS];
  assign out_tlast  = q_head[X_BITS+Y_BITS+1];

endmodule

/* rtl/llbd_dist.sv */
`timescale 1ns / 1ps

// Squared distance of a point to the anchor: dx*dx*2^16 + dy*dy, saturating.
module llbd_dist #(
  parameter int X_BITS = 16,
  parameter int Y_BITS = 24
) (
  input  logic [X_BITS-1:0]                  px,
  input  logic [Y_BITS-1:0]                  py,
  input  logic [X_BITS-1:0]                  ax,
  input  logic [Y_BITS-1:0]                  ay,
  output logic [llbd_pkg::DIST_BITS-1:0]     dist_sq
);

  logic [X_BITS:0]                   dx;
  logic [Y_BITS:0]                   dy;
  logic [X_BITS-1:0]                 ux;
  logic [Y_BITS-1:0]                 uy;
  logic [2*X_BITS-1:0]               xsq;
  logic [2*Y_BITS-1:0]               ysq;
  logic [63:0]                       xsq64;
  logic [63:0]                       ysq64;
  logic [llbd_pkg::DIST_BITS-1:0]    xsat;
  logic [llbd_pkg::DIST_BITS-1:0]    ysat;
  logic [llbd_pkg::DIST_BITS-1:0]    xsh;
  logic [llbd_pkg::DIST_BITS:0]      sum;

  assign dx = {px[X_BITS-1], px} - {ax[X_BITS-1], ax};
  assign dy = {py[Y_BITS-1], py} - {ay[Y_BITS-1], ay};

  // Magnitude always fits the field width.
  assign ux = dx[X_BITS] ? X_BITS'(-dx) : dx[X_BITS-1:0];
  assign uy = dy[Y_BITS] ? Y_BITS'(-dy) : dy[Y_BITS-1:0];

  assign xsq = ux * ux;
  assign ysq = uy * uy;

  assign xsq64 = 64'(xsq);
  assign ysq64 = 64'(ysq);

  assign xsat = (xsq64 > 64'(llbd_pkg::DIST_MAX)) ? llbd_pkg::DIST_MAX
                                                  : xsq64[llbd_pkg::DIST_BITS-1:0];
  assign ysat = (ysq64 > 64'(llbd_pkg::DIST_MAX)) ? llbd_pkg::DIST_MAX
                                                  : ysq64[llbd_pkg::DIST_BITS-1:0];

  assign xsh = (xsat > llbd_pkg::XS_LIMIT) ? llbd_pkg::DIST_MAX
                                           : (xsat << llbd_pkg::SQ_SHIFT);

  assign sum     = {1'b0, xsh} + {1'b0, ysat};
  assign dist_sq = sum[llbd_pkg::DIST_BITS] ? llbd_pkg::DIST_MAX
                                            : sum[llbd_pkg::DIST_BITS-1:0];

endmodule

/* rtl/llbd_outq.sv */
`timescale 1ns / 1ps

// Two-entry result queue; head entry drives the output port.
module llbd_outq #(
  parameter int W = 42
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    push_n,
  input  logic [W-1:0]                  push0,
  input  logic [W-1:0]                  push1,
  input  logic                          pop,
  output logic                          head_valid,
  output logic [W-1:0]                  head,
  output logic [llbd_pkg::Q_CNT_W-1:0]  count
);

  logic [W-1:0]                  q_r   [llbd_pkg::Q_DEPTH];
  logic [W-1:0]                  q_nxt [llbd_pkg::Q_DEPTH];
  logic [llbd_pkg::Q_CNT_W-1:0]  cnt_r;
  logic [llbd_pkg::Q_CNT_W-1:0]  cnt_nxt;
  logic [llbd_pkg::Q_CNT_W-1:0]  base;

  // Occupancy after this cycle's pop.
  assign base = cnt_r - llbd_pkg::Q_CNT_W'(pop);

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push_n != llbd_pkg::NRES_NONE) begin
      q_nxt[base[0]] = push0;
    end
    // Two pushes only ever land on an empty queue.
    if (push_n == llbd_pkg::NRES_TWO) begin
      q_nxt[1] = push1;
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[0];
  assign count      = cnt_r;

endmodule

/* rtl/llbd_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llbd_checker #(
  parameter int X_BITS = 16,
  parameter int Y_BITS = 24
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic [((X_BITS+Y_BITS+7)/8)*8-1:0]  out_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic                                out_tuser,
  input logic                                out_tlast
);

  // A stalled output beat holds.
  `LLBD_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // Endpoints always close the results of their item.
  `LLBD_ASSERT_IMP(a_endp_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)

  // A flushed bucket point is followed at once by the series endpoint.
  `LLBD_ASSERT_NXT(a_flush_pair, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tuser && out_tlast)

  // Nothing is offered right after reset.
  `LLBD_ASSERT_IMP(a_reset_idle, clk, rst_n, !$past(rst_n), !out_tvalid)

endmodule

bind longest_line_bucket_downsampler llbd_checker #(
  .X_BITS (X_BITS),
  .Y_BITS (Y_BITS)
) u_llbd_checker (.*);

/* verif/longest_line_bucket_downsampler_tb.sv */
`timescale 1ns / 1ps

module longest_line_bucket_downsampler_tb;

  localparam int X_W = 16;
  localparam int Y_W = 24;
  localparam int TD_W = ((X_W + Y_W + 7) / 8) * 8;
  localparam int FRAC_SHIFT = 16;          // x square is scaled to the y square's Q16 units
  localparam logic [50:0] DIST_CEIL = '1;
  localparam int SETTLE_CYCLES = 6;        // covers the input stage plus margin
  localparam int STALL_LIMIT = 2000;       // cycles with no beat on any channel
  localparam int PHASE_ITEMS = 155;

  // One result beat: out_x, out_y, is_endpoint, last_of_run.
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  endp;
    logic                  fin;
  } point_res_t;

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_e;

  // One row of the directed table. n_typed > 0 means the results are spelled out
  // in t0/t1; zero means the row is checked against the running prediction.
  typedef struct packed {
    row_kind_e             kind;
    logic [15:0]           cfg;
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  first;
    logic                  last;
    logic [1:0]            n_typed;
    point_res_t            t0;
    point_res_t            t1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [TD_W-1:0] in_tdata = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic            in_tuser = 1'b0;
  logic            in_tlast = 1'b0;
  logic [TD_W-1:0] out_tdata;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic            out_tuser;
  logic            out_tlast;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [15:0]     cfg_data = '0;

  // Shadow of the block's state, advanced on every accepted input beat.
  logic [15:0]           bucket_len;
  logic signed [X_W-1:0] anc_x, best_x;
  logic signed [Y_W-1:0] anc_y, best_y;
  logic [50:0]           best_dist;
  logic [15:0]           fill;

  point_res_t pending_points[$];

  int send_idle_pct = 8;
  int recv_idle_pct = 87;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int idle_cycles = 0;
  logic signed [X_W-1:0] prev_x = '0;
  logic signed [Y_W-1:0] prev_y = '0;

  wire beat_moved = (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                    (cfg_valid && cfg_ready);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  longest_line_bucket_downsampler #(
    .X_BITS(X_W),
    .Y_BITS(Y_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic point_res_t pt(int x, int y, bit e, bit f);
    point_res_t r;
    r.x = X_W'(x);
    r.y = Y_W'(y);
    r.endp = e;
    r.fin = f;
    return r;
  endfunction

  // Squared distance to the anchor in Q16: dx*dx scaled up, plus the raw dy*dy.
  // Exact at these widths; clamp anyway so wider fields keep the saturating rule.
  function automatic logic [50:0] anchor_dist(logic signed [X_W-1:0] x,
                                              logic signed [Y_W-1:0] y);
    longint dx, dy;
    longint unsigned sum;
    dx = longint'(x) - longint'(anc_x);
    dy = longint'(y) - longint'(anc_y);
    sum = (longint'(dx * dx) << FRAC_SHIFT) + longint'(dy * dy);
    return (sum > longint'(DIST_CEIL)) ? DIST_CEIL : sum[50:0];
  endfunction

  task automatic restart_series(input logic signed [X_W-1:0] x,
                                input logic signed [Y_W-1:0] y);
    anc_x = x;
    anc_y = y;
    best_x = x;
    best_y = y;
    best_dist = '0;
    fill = '0;
  endtask

  // Advance the shadow state by one input point and hand back what it emits.
  task automatic downsample_point(input logic signed [X_W-1:0] x,
                                  input logic signed [Y_W-1:0] y,
                                  input bit first, input bit last,
                                  output int n, output point_res_t r0,
                                  output point_res_t r1);
    logic [16:0] limit;
    logic [50:0] d;
    limit = (bucket_len == 0) ? 17'd1 : {1'b0, bucket_len};
    n = 0;
    r0 = '0;
    r1 = '0;
    if (first) begin
      r0 = '{x, y, 1'b1, 1'b1};
      n = 1;
      restart_series(x, y);
    end else if (last) begin
      // Flush a partial bucket ahead of the closing point.
      if (fill != 0) begin
        r0 = '{best_x, best_y, 1'b0, 1'b0};
        r1 = '{x, y, 1'b1, 1'b1};
        n = 2;
      end else begin
        r0 = '{x, y, 1'b1, 1'b1};
        n = 1;
      end
      restart_series(x, y);
    end else begin
      d = anchor_dist(x, y);
      // Strictly greater only: a tie keeps the earlier point.
      if (d > best_dist) begin
        best_dist = d;
        best_x = x;
        best_y = y;
      end
      fill = fill + 16'd1;
      if ({1'b0, fill} >= limit) begin
        r0 = '{best_x, best_y, 1'b0, 1'b1};
        n = 1;
        restart_series(best_x, best_y);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Drive one point beat, hold it until taken, then queue its expected results.
  task automatic send_point(input logic signed [X_W-1:0] x, input logic signed [Y_W-1:0] y,
                            input bit first, input bit last, input int n_typed = 0,
                            input point_res_t t0 = '0, input point_res_t t1 = '0);
    int n;
    point_res_t p0, p1;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tuser <= first;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    prev_x = x;
    prev_y = y;
    downsample_point(x, y, first, last, n, p0, p1);
    if (n_typed > 0) begin
      pending_points = {pending_points, t0};
      if (n_typed > 1) pending_points = {pending_points, t1};
    end else begin
      if (n > 0) pending_points = {pending_points, p0};
      if (n > 1) pending_points = {pending_points, p1};
    end
  endtask

  // Drop valid, drain every expected beat, then let the input stage settle:
  // an interior point may still be in flight with nothing to show for it.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_size(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bucket_len = v;
    n_cfg++;
  endtask

  function automatic logic signed [X_W-1:0] pick_x();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return X_W'($urandom_range(0, 32)) - 16'sd16;
      default: return X_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [Y_W-1:0] pick_y();
    case ($urandom_range(0, 5))
      0:       return 24'sh800000;
      1:       return 24'sh7FFFFF;
      2, 3:    return Y_W'($urandom_range(0, 1024)) - 24'sd512;
      default: return Y_W'($urandom);
    endcase
  endfunction

  // Mostly complete series with random content; the rest is stray flags,
  // series left open, and interior points with no opening point.
  task automatic run_phase(input logic [15:0] bsz, input int snd_pct, input int rcv_pct);
    int start, len, eff;
    wait_idle();
    write_bucket_size(bsz);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    eff = (bsz == 0) ? 1 : int'(bsz);
    start = n_items;
    while (n_items - start < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        8: begin
          repeat ($urandom_range(1, 4))
            send_point(pick_x(), pick_y(), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0);
        end
        9: begin
          if ($urandom_range(0, 1) == 1) send_point(pick_x(), pick_y(), 1'b1, 1'b0);
          repeat ($urandom_range(1, 6)) send_point(pick_x(), pick_y(), 1'b0, 1'b0);
        end
        default: begin
          len = (eff <= 8) ? $urandom_range(0, 4 * eff + 1) : $urandom_range(0, 12);
          send_point(pick_x(), pick_y(), 1'b1, 1'b0);
          repeat (len) begin
            // Repeat the previous point now and then to hit ties and zero distance.
            if ($urandom_range(0, 5) == 0) send_point(prev_x, prev_y, 1'b0, 1'b0);
            else send_point(pick_x(), pick_y(), 1'b0, 1'b0);
          end
          send_point(pick_x(), pick_y(), 1'b0, 1'b1);
        end
      endcase
      // Hold off the sender until the output side has caught up.
      if ($urandom_range(0, 15) == 0) wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s at result beat %0d: got %0h, expected %0h",
             what, n_results, got, want);
  endtask

  always @(posedge clk) begin : result_check
    point_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, 0);
      end else begin
        want = pending_points.pop_front();
        if (out_tdata[X_W-1:0] !== want.x)
          report_mismatch("out_x", out_tdata[X_W-1:0], want.x);
        if (out_tdata[X_W+Y_W-1:X_W] !== want.y)
          report_mismatch("out_y", out_tdata[X_W+Y_W-1:X_W], want.y);
        if (out_tuser !== want.endp) report_mismatch("is_endpoint", out_tuser, want.endp);
        if (out_tlast !== want.fin) report_mismatch("last_of_run", out_tlast, want.fin);
      end
    end
  end

  // Advance the stall count on every cycle where no channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || beat_moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  function automatic stim_row_t pt_row(int x, int y, bit first, bit last, int n = 0,
                                       point_res_t t0 = '0, point_res_t t1 = '0);
    stim_row_t r;
    r = '0;
    r.kind = ROW_POINT;
    r.x = X_W'(x);
    r.y = Y_W'(y);
    r.first = first;
    r.last = last;
    r.n_typed = 2'(n);
    r.t0 = t0;
    r.t1 = t1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [15:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg = v;
    return r;
  endfunction

  initial begin : main_seq
    stim_row_t directed[$];

    // Bucket size is one out of reset, so each interior point emits on its own.
    // Interior point before any opening point: measured from the origin.
    directed = {directed, pt_row(100, 256, 0, 0, 1, pt(100, 256, 0, 1))};
    // Same point as the anchor: nothing farther, so the anchor comes back.
    directed = {directed, pt_row(100, 256, 0, 0, 1, pt(100, 256, 0, 1))};
    directed = {directed, pt_row(-32768, -8388608, 1, 0, 1, pt(-32768, -8388608, 1, 1))};
    directed = {directed, pt_row(32767, 8388607, 0, 0, 1, pt(32767, 8388607, 0, 1))};
    // Closing point with an empty bucket: only itself.
    directed = {directed, pt_row(-1, -1, 0, 1, 1, pt(-1, -1, 1, 1))};
    // Opening and closing flags on one point: a single result.
    directed = {directed, pt_row(5, -5, 1, 1, 1, pt(5, -5, 1, 1))};
    directed = {directed, cfg_row(16'd3)};
    directed = {directed, pt_row(0, 0, 1, 0, 1, pt(0, 0, 1, 1))};
    // One unit of x outweighs 255/256 of y but not 257/256.
    directed = {directed, pt_row(1, 0, 0, 0)};
    directed = {directed, pt_row(0, 255, 0, 0)};
    directed = {directed, pt_row(0, 257, 0, 0)};
    // Equal distances on both sides: the earlier point is kept.
    directed = {directed, pt_row(0, -257, 0, 0)};
    directed = {directed, pt_row(0, 771, 0, 0)};
    // Partial bucket flushed ahead of the closing point.
    directed = {directed, pt_row(-1, 0, 0, 1)};
    // Partial bucket holding only the anchor itself.
    directed = {directed, pt_row(-1, 0, 0, 0)};
    directed = {directed, pt_row(-1, 0, 0, 1)};
    // Bucket size zero behaves as one.
    directed = {directed, cfg_row(16'd0)};
    directed = {directed, pt_row(10, 10, 1, 0)};
    directed = {directed, pt_row(-32768, 8388607, 0, 0)};
    directed = {directed, pt_row(7, -8, 0, 1)};
    // Largest bucket: only the closing point flushes it.
    directed = {directed, cfg_row(16'hFFFF)};
    directed = {directed, pt_row(0, 0, 1, 0)};
    directed = {directed, pt_row(32767, -8388608, 0, 0)};
    directed = {directed, pt_row(12, 34, 0, 0)};
    directed = {directed, pt_row(3, 3, 0, 1)};

    bucket_len = 16'd1;
    restart_series('0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        write_bucket_size(directed[i].cfg);
      end else begin
        send_point(directed[i].x, directed[i].y, directed[i].first, directed[i].last,
                   directed[i].n_typed, directed[i].t0, directed[i].t1);
      end
    end

    // Sender dense / receiver mostly stalled, then swapped, then full rate.
    run_phase(16'd0, 8, 87);
    run_phase(16'hFFFF, 8, 87);
    run_phase(16'd2, 87, 8);
    run_phase(16'($urandom_range(3, 9)), 87, 8);
    run_phase(16'd1, 0, 0);
    run_phase(16'($urandom_range(2, 20)), 0, 0);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d point beats and checked %0d result beats over %0d bucket sizes,",
             n_items, n_results, n_cfg);
    $display("including sizes 0, 1, 2 and 65535, under sender and receiver stalls.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
